// ----- design/qmlp_pkg.sv -----
package qmlp_pkg;

  localparam int NUM_FEATURES_DEF = 4;
  localparam int NUM_HIDDEN_DEF   = 32;
  localparam int NUM_CLASSES_DEF  = 4;

  // accumulator width: 32-bit bias plus the largest dot product
  localparam int ACC_W     = 34;
  localparam int TAG_W     = 7;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_LIM   = 1024;
  localparam int Q_MAX     = 127;
  localparam int Q_MIN     = -128;

  typedef enum logic {
    ACT_LOAD     = 1'b0,
    ACT_CLASSIFY = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIDDEN_MULT  = 3'd0,
    REG_HIDDEN_SHIFT = 3'd1,
    REG_HIDDEN_ZP    = 3'd2,
    REG_SCORE_MULT   = 3'd3,
    REG_SCORE_SHIFT  = 3'd4,
    REG_SCORE_ZP     = 3'd5
  } reg_idx_e;

  // hidden value travelling along the row of class cells
  typedef struct packed {
    logic              valid;
    logic signed [7:0] h;
    logic [TAG_W-1:0]  idx;
  } qmlp_link_t;

endpackage

// ----- design/qmlp_cell.sv -----
module qmlp_cell #(
  parameter int NUM_HIDDEN = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_weight_i,
  input  logic                         wr_bias_i,
  input  logic [(NUM_HIDDEN > 1 ? $clog2(NUM_HIDDEN) : 1)-1:0] wr_addr_i,
  input  logic [31:0]                  wr_data_i,
  input  qmlp_pkg::qmlp_link_t         link_i,
  output qmlp_pkg::qmlp_link_t         link_o,
  output logic signed [qmlp_pkg::ACC_W-1:0] acc_o
);
  import qmlp_pkg::*;

  localparam int HW = NUM_HIDDEN > 1 ? $clog2(NUM_HIDDEN) : 1;

  logic signed [7:0]       mem [NUM_HIDDEN];
  logic signed [7:0]       w_q;
  logic signed [31:0]      bias_q;
  qmlp_link_t              stage_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [15:0]      prod;

  always_ff @(posedge clk_i) begin
    if (wr_weight_i) begin
      mem[wr_addr_i] <= wr_data_i[7:0];
    end
    if (wr_bias_i) begin
      bias_q <= wr_data_i;
    end
    w_q <= mem[link_i.idx[HW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= link_i;
    end
  end

  always_comb begin
    prod = stage_q.h * w_q;
    if (stage_q.idx == '0) begin
      acc_d = ACC_W'(bias_q) + {{(ACC_W-16){prod[15]}}, prod};
    end else begin
      acc_d = acc_q + {{(ACC_W-16){prod[15]}}, prod};
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign link_o = stage_q;
  assign acc_o  = acc_q;

endmodule

// ----- design/qmlp_requant.sv -----
module qmlp_requant (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic signed [qmlp_pkg::ACC_W-1:0] in_acc_i,
  input  logic [qmlp_pkg::TAG_W-1:0]        in_tag_i,
  input  logic [qmlp_pkg::CFG_W-1:0]        mult_i,
  input  logic [5:0]                        shift_i,
  input  logic signed [7:0]                 zp_i,
  input  logic                              relu_i,
  output logic                              out_valid_o,
  output logic signed [7:0]                 out_q_o,
  output logic [qmlp_pkg::TAG_W-1:0]        out_tag_o
);
  import qmlp_pkg::*;

  localparam int LO_W   = 17;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int PP_W   = LO_W + CFG_W;
  localparam int PROD_W = ACC_W + CFG_W;
  localparam int SAT_W  = $clog2(SAT_LIM) + 1;

  logic [3:0]             v_q;
  logic [TAG_W-1:0]       tag_q [4];
  logic [3:0]             neg_q;
  logic [ACC_W-1:0]       mag;
  logic [HI_W-1:0]        mag_hi_q;
  logic [PP_W-1:0]        lo_q;
  logic [PROD_W-1:0]      prod_q;
  logic [PROD_W-1:0]      shifted;
  logic [SAT_W-1:0]       sat_q;
  logic signed [12:0]     sq, q;
  logic signed [7:0]      q_q;

  assign mag = in_acc_i[ACC_W-1] ? ACC_W'(-in_acc_i) : ACC_W'(in_acc_i);
  assign shifted = prod_q >> shift_i;

  always_comb begin
    sq = sat_q[SAT_W-1] ? 13'sd1024 : 13'(signed'({1'b0, sat_q}));
    if (neg_q[2]) begin
      sq = -sq;
    end
    q = sq + 13'(zp_i);
    if (relu_i && q < 13'(zp_i)) begin
      q = 13'(zp_i);
    end
    if (q > 13'(Q_MAX)) begin
      q = 13'(Q_MAX);
    end else if (q < 13'(Q_MIN)) begin
      q = 13'(Q_MIN);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_hi_q <= mag[ACC_W-1:LO_W];
    lo_q     <= mag[LO_W-1:0] * mult_i;
    prod_q   <= {PP_W'(mag_hi_q) * PP_W'(mult_i), {LO_W{1'b0}}} + PROD_W'(lo_q);
    if (shifted > PROD_W'(SAT_LIM)) begin
      sat_q <= SAT_W'(SAT_LIM);
    end else begin
      sat_q <= shifted[SAT_W-1:0];
    end
    q_q <= q[7:0];
    tag_q[0] <= in_tag_i;
    tag_q[1] <= tag_q[0];
    tag_q[2] <= tag_q[1];
    tag_q[3] <= tag_q[2];
    neg_q <= {neg_q[2:0], in_acc_i[ACC_W-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  assign out_valid_o = v_q[3];
  assign out_q_o     = q_q;
  assign out_tag_o   = tag_q[3];

endmodule

// ----- design/quantized_mlp_classifier.sv -----
// Load word: stored when accepted, no result.
// Classify word: layer-one multiply-accumulate, requantize, the row of class cells,
// then requantize the scores and pick the best class.
// One classification at a time; loads are taken while a result waits at the output.
// Reset restores the scale and zero-point registers; weight and bias stores are
// undefined until loaded.
module quantized_mlp_classifier #(
  parameter int NUM_FEATURES = qmlp_pkg::NUM_FEATURES_DEF,
  parameter int NUM_HIDDEN   = qmlp_pkg::NUM_HIDDEN_DEF,
  parameter int NUM_CLASSES  = qmlp_pkg::NUM_CLASSES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [qmlp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [qmlp_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [8:0]                         store_address_i,
  input  logic signed [31:0]                 store_value_i,
  input  logic signed [7:0]                  feature_0_i,
  input  logic signed [7:0]                  feature_1_i,
  input  logic signed [7:0]                  feature_2_i,
  input  logic signed [7:0]                  feature_3_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [7:0]                  score_0_o,
  output logic signed [7:0]                  score_1_o,
  output logic signed [7:0]                  score_2_o,
  output logic signed [7:0]                  score_3_o,
  output logic [1:0]                         best_class_o
);
  import qmlp_pkg::*;

  localparam int FW    = NUM_FEATURES > 1 ? $clog2(NUM_FEATURES) : 1;
  localparam int HW    = NUM_HIDDEN > 1 ? $clog2(NUM_HIDDEN) : 1;
  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int W1D   = NUM_FEATURES * NUM_HIDDEN;
  localparam int W1AW  = W1D > 1 ? $clog2(W1D) : 1;
  localparam int B1_BASE = W1D;
  localparam int W2_BASE = B1_BASE + NUM_HIDDEN;
  localparam int B2_BASE = W2_BASE + NUM_HIDDEN * NUM_CLASSES;
  localparam int ST_END  = B2_BASE + NUM_CLASSES;
  localparam int RK      = 16;
  localparam int RECIP   = (2 ** RK + NUM_CLASSES - 1) / NUM_CLASSES;

  typedef enum logic [2:0] {
    ST_IDLE, ST_L1, ST_L1_WAIT, ST_L2, ST_L2_WAIT, ST_FINISH
  } state_e;

  state_e state_q;

  // configuration
  logic [CFG_W-1:0]  hmult_q, smult_q;
  logic [5:0]        hshift_q, sshift_q;
  logic signed [7:0] hzp_q, szp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hmult_q  <= CFG_W'(1073741824);
      hshift_q <= 6'd31;
      hzp_q    <= '0;
      smult_q  <= CFG_W'(1073741824);
      sshift_q <= 6'd31;
      szp_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HIDDEN_MULT:  hmult_q  <= cfg_wdata_i;
        REG_HIDDEN_SHIFT: hshift_q <= cfg_wdata_i[5:0];
        REG_HIDDEN_ZP:    hzp_q    <= cfg_wdata_i[7:0];
        REG_SCORE_MULT:   smult_q  <= cfg_wdata_i;
        REG_SCORE_SHIFT:  sshift_q <= cfg_wdata_i[5:0];
        REG_SCORE_ZP:     szp_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic        accept, is_load;
  logic [31:0] addr32;
  logic [8:0]  w2_off;
  logic [25:0] w2_j_full;
  logic [8:0]  w2_j, w2_c;
  logic [8:0]  b2_c;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = accept && (action_i == ACT_LOAD);
  assign addr32     = 32'(store_address_i);
  assign w2_off     = 9'(addr32 - 32'(W2_BASE));
  assign w2_j_full  = 26'(w2_off) * 26'(RECIP);
  assign w2_j       = 9'(w2_j_full >> RK);
  assign w2_c       = 9'(w2_off - 9'(w2_j * 9'(NUM_CLASSES)));
  assign b2_c       = 9'(addr32 - 32'(B2_BASE));

  // layer one store
  logic signed [7:0]  w1_mem [W1D];
  logic signed [31:0] b1_mem [NUM_HIDDEN];
  logic signed [7:0]  w1_rd_q;
  logic signed [31:0] b1_rd_q;
  logic [W1AW-1:0]    w1_addr_q;
  logic [FW-1:0]      cnt_i_q;
  logic [HW-1:0]      cnt_j_q;

  always_ff @(posedge clk_i) begin
    if (is_load && addr32 < 32'(B1_BASE)) begin
      w1_mem[W1AW'(addr32)] <= store_value_i[7:0];
    end
    if (is_load && addr32 >= 32'(B1_BASE) && addr32 < 32'(W2_BASE)) begin
      b1_mem[HW'(addr32 - 32'(B1_BASE))] <= store_value_i;
    end
    w1_rd_q <= w1_mem[w1_addr_q];
    b1_rd_q <= b1_mem[cnt_j_q];
  end

  // features
  logic signed [7:0] in_feat [4];
  logic signed [7:0] feat_q [NUM_FEATURES];

  assign in_feat[0] = feature_0_i;
  assign in_feat[1] = feature_1_i;
  assign in_feat[2] = feature_2_i;
  assign in_feat[3] = feature_3_i;

  always_ff @(posedge clk_i) begin
    if (accept && action_i == ACT_CLASSIFY) begin
      for (int k = 0; k < NUM_FEATURES; k++) begin
        feat_q[k] <= (k < 4) ? in_feat[k % 4] : 8'sd0;
      end
    end
  end

  // layer one multiply-accumulate
  logic                    rd_v_q;
  logic [FW-1:0]           rd_i_q;
  logic [HW-1:0]           rd_j_q;
  logic signed [ACC_W-1:0] acc1_q, acc1_d;
  logic signed [15:0]      prod1;
  logic                    fin_q;
  logic [HW-1:0]           fin_j_q;

  always_comb begin
    prod1 = feat_q[rd_i_q] * w1_rd_q;
    if (rd_i_q == '0) begin
      acc1_d = ACC_W'(b1_rd_q) + {{(ACC_W-16){prod1[15]}}, prod1};
    end else begin
      acc1_d = acc1_q + {{(ACC_W-16){prod1[15]}}, prod1};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_i_q  <= cnt_i_q;
    rd_j_q  <= cnt_j_q;
    fin_j_q <= rd_j_q;
    if (rd_v_q) begin
      acc1_q <= acc1_d;
    end
  end

  // requantizer feed
  logic                     req_v_q;
  logic signed [ACC_W-1:0]  req_acc_q;
  logic [TAG_W-1:0]         req_tag_q;
  logic                     layer2_q;
  logic [CW-1:0]            cnt_c_q;
  logic signed [ACC_W-1:0]  cell_acc [NUM_CLASSES];
  logic                     rq_v;
  logic signed [7:0]        rq_q;
  logic [TAG_W-1:0]         rq_tag;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_L2) begin
      req_acc_q <= cell_acc[cnt_c_q];
      req_tag_q <= TAG_W'(cnt_c_q);
    end else begin
      req_acc_q <= acc1_q;
      req_tag_q <= TAG_W'(fin_j_q);
    end
  end

  qmlp_requant u_requant (
    .clk_i,
    .rst_ni,
    .in_valid_i  (req_v_q),
    .in_acc_i    (req_acc_q),
    .in_tag_i    (req_tag_q),
    .mult_i      (layer2_q ? smult_q : hmult_q),
    .shift_i     (layer2_q ? sshift_q : hshift_q),
    .zp_i        (layer2_q ? szp_q : hzp_q),
    .relu_i      (!layer2_q),
    .out_valid_o (rq_v),
    .out_q_o     (rq_q),
    .out_tag_o   (rq_tag)
  );

  // row of class cells
  qmlp_link_t links [NUM_CLASSES+1];

  always_comb begin
    links[0].valid = rq_v && !layer2_q;
    links[0].h     = rq_q;
    links[0].idx   = rq_tag;
  end

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cell
    qmlp_cell #(.NUM_HIDDEN(NUM_HIDDEN)) u_cell (
      .clk_i,
      .rst_ni,
      .wr_weight_i (is_load && addr32 >= 32'(W2_BASE) && addr32 < 32'(B2_BASE)
                    && w2_c == 9'(c)),
      .wr_bias_i   (is_load && addr32 >= 32'(B2_BASE) && addr32 < 32'(ST_END)
                    && b2_c == 9'(c)),
      .wr_addr_i   (HW'(w2_j)),
      .wr_data_i   (store_value_i),
      .link_i      (links[c]),
      .link_o      (links[c+1]),
      .acc_o       (cell_acc[c])
    );
  end

  logic chain_last;
  assign chain_last = links[NUM_CLASSES].valid
                      && links[NUM_CLASSES].idx == TAG_W'(NUM_HIDDEN - 1);

  // scores and argmax
  logic signed [7:0] scores_q [NUM_CLASSES];
  logic signed [7:0] best_val_q;
  logic [CW-1:0]     best_idx_q;
  logic signed [7:0] score_o_q [4];
  logic [1:0]        best_o_q;
  logic              out_valid_q;

  always_ff @(posedge clk_i) begin
    if (rq_v && layer2_q) begin
      scores_q[CW'(rq_tag)] <= rq_q;
      if (rq_tag == '0 || rq_q > best_val_q) begin
        best_val_q <= rq_q;
        best_idx_q <= CW'(rq_tag);
      end
    end
    if (state_q == ST_FINISH && (!out_valid_q || out_ready_i)) begin
      for (int k = 0; k < 4; k++) begin
        score_o_q[k] <= (k < NUM_CLASSES) ? scores_q[k % NUM_CLASSES] : 8'sd0;
      end
      best_o_q <= 2'(best_idx_q);
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_i_q     <= '0;
      cnt_j_q     <= '0;
      w1_addr_q   <= '0;
      cnt_c_q     <= '0;
      rd_v_q      <= 1'b0;
      fin_q       <= 1'b0;
      req_v_q     <= 1'b0;
      layer2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q  <= (state_q == ST_L1);
      fin_q   <= rd_v_q && rd_i_q == FW'(NUM_FEATURES - 1);
      req_v_q <= (state_q == ST_L2) || fin_q;
      if (out_valid_q && out_ready_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_i_q   <= '0;
          cnt_j_q   <= '0;
          w1_addr_q <= '0;
          cnt_c_q   <= '0;
          layer2_q  <= 1'b0;
          if (accept && action_i == ACT_CLASSIFY) begin
            state_q <= ST_L1;
          end
        end
        ST_L1: begin
          // walk feature-fastest so each hidden sum completes in turn
          if (cnt_i_q == FW'(NUM_FEATURES - 1)) begin
            cnt_i_q   <= '0;
            cnt_j_q   <= cnt_j_q + 1'b1;
            w1_addr_q <= W1AW'(cnt_j_q) + 1'b1;
            if (cnt_j_q == HW'(NUM_HIDDEN - 1)) begin
              state_q <= ST_L1_WAIT;
            end
          end else begin
            cnt_i_q   <= cnt_i_q + 1'b1;
            w1_addr_q <= w1_addr_q + W1AW'(NUM_HIDDEN);
          end
        end
        ST_L1_WAIT: begin
          if (chain_last) begin
            layer2_q <= 1'b1;
            state_q  <= ST_L2;
          end
        end
        ST_L2: begin
          cnt_c_q <= cnt_c_q + 1'b1;
          if (cnt_c_q == CW'(NUM_CLASSES - 1)) begin
            state_q <= ST_L2_WAIT;
          end
        end
        ST_L2_WAIT: begin
          if (rq_v && rq_tag == TAG_W'(NUM_CLASSES - 1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign score_0_o    = score_o_q[0];
  assign score_1_o    = score_o_q[1];
  assign score_2_o    = score_o_q[2];
  assign score_3_o    = score_o_q[3];
  assign best_class_o = best_o_q;

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  import qmlp_pkg::*;

  localparam int LATENCY   = 200;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 320;

  typedef struct packed {
    logic        action;
    logic [8:0]  addr;
    logic [31:0] value;
    logic [7:0]  f0, f1, f2, f3;
  } in_word_t;

  typedef struct packed {
    logic [7:0] s0, s1, s2, s3;
    logic [1:0] best;
  } score_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [8:0]  store_address_i = '0;
  logic signed [31:0] store_value_i = '0;
  logic signed [7:0]  feature_0_i = '0, feature_1_i = '0, feature_2_i = '0, feature_3_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [7:0]  score_0_o, score_1_o, score_2_o, score_3_o;
  logic [1:0]  best_class_o;

  quantized_mlp_classifier u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [7:0]  w1 [128];
  logic signed [31:0] b1 [32];
  logic signed [7:0]  w2 [128];
  logic signed [31:0] b2 [4];
  logic [30:0] h_mult, s_mult;
  logic [5:0]  h_shift, s_shift;
  logic signed [7:0] h_zp, s_zp;

  in_word_t    pending_q[$];
  score_word_t scores_q[$];
  int  n_fail = 0;
  bit  quiet_rx = 1'b0;     // no random stalls on the receiver
  bit  quiet_tx = 1'b0;
  bit  hold_rx = 1'b0;
  bit  in_ready_seen = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    n_fail++;
  endtask

  function automatic longint requant(longint acc, logic [30:0] mult, logic [5:0] sh,
                                     longint zp, bit relu);
    longint unsigned mag, s;
    longint q;
    mag = acc < 0 ? -acc : acc;
    s = (mag * longint'(mult)) >> sh;
    if (s > SAT_LIM) s = SAT_LIM;
    q = acc < 0 ? -longint'(s) : longint'(s);
    q += zp;
    if (relu && q < zp) q = zp;
    if (q > Q_MAX) q = Q_MAX;
    if (q < Q_MIN) q = Q_MIN;
    return q;
  endfunction

  function automatic score_word_t classify(in_word_t w);
    longint feat [4];
    longint hid [32];
    longint sc [4];
    longint acc;
    score_word_t r;
    int best;
    feat[0] = $signed(w.f0); feat[1] = $signed(w.f1);
    feat[2] = $signed(w.f2); feat[3] = $signed(w.f3);
    for (int j = 0; j < 32; j++) begin
      acc = b1[j];
      for (int i = 0; i < 4; i++) acc += feat[i] * w1[i*32+j];
      hid[j] = requant(acc, h_mult, h_shift, h_zp, 1'b1);
    end
    for (int j = 0; j < 4; j++) begin
      acc = b2[j];
      for (int i = 0; i < 32; i++) acc += hid[i] * w2[i*4+j];
      sc[j] = requant(acc, s_mult, s_shift, s_zp, 1'b0);
    end
    best = 0;
    for (int j = 1; j < 4; j++) if (sc[j] > sc[best]) best = j;
    r.s0 = sc[0][7:0]; r.s1 = sc[1][7:0]; r.s2 = sc[2][7:0]; r.s3 = sc[3][7:0];
    r.best = best[1:0];
    return r;
  endfunction

  // prediction at acceptance keeps store/config order exact
  function automatic void absorb(in_word_t w);
    if (w.action == ACT_LOAD) begin
      if (w.addr < 128) w1[w.addr] = w.value[7:0];
      else if (w.addr < 160) b1[w.addr-128] = w.value;
      else if (w.addr < 288) w2[w.addr-160] = w.value[7:0];
      else if (w.addr < 292) b2[w.addr-288] = w.value;
    end else begin
      scores_q.push_back(classify(w));
    end
  endfunction

  // driver
  int unsigned wdog = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_seen) begin
        if (pending_q.size() > 0 && (quiet_tx || $urandom_range(99) >= 30)) begin
          in_word_t w;
          w = pending_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= w.action; store_address_i <= w.addr; store_value_i <= w.value;
          feature_0_i <= w.f0; feature_1_i <= w.f1;
          feature_2_i <= w.f2; feature_3_i <= w.f3;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !hold_rx && (quiet_rx || $urandom_range(99) >= 30);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    in_ready_seen = in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_ready_seen) absorb({action_i, store_address_i, store_value_i,
                                 feature_0_i, feature_1_i, feature_2_i, feature_3_i});
      if (out_valid_o && out_ready_i) begin
        score_word_t e;
        if (scores_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = scores_q.pop_front();
          if (score_0_o !== e.s0) report($sformatf("score_0 %0d exp %0d", score_0_o, $signed(e.s0)));
          if (score_1_o !== e.s1) report($sformatf("score_1 %0d exp %0d", score_1_o, $signed(e.s1)));
          if (score_2_o !== e.s2) report($sformatf("score_2 %0d exp %0d", score_2_o, $signed(e.s2)));
          if (score_3_o !== e.s3) report($sformatf("score_3 %0d exp %0d", score_3_o, $signed(e.s3)));
          if (best_class_o !== e.best) report($sformatf("best_class %0d exp %0d", best_class_o, e.best));
        end
      end
      if (in_ready_seen || (out_valid_o && out_ready_i) || hold_rx) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic in_word_t load_word(int addr, logic [31:0] v);
    in_word_t w;
    w = '0;
    w.action = ACT_LOAD; w.addr = addr[8:0]; w.value = v;
    return w;
  endfunction

  function automatic in_word_t feat_word(logic [7:0] a, b, c, d);
    in_word_t w;
    w = '0;
    w.action = ACT_CLASSIFY; w.f0 = a; w.f1 = b; w.f2 = c; w.f3 = d;
    w.addr = 9'($urandom()); w.value = $urandom();
    return w;
  endfunction

  function automatic logic [31:0] rnd_bias();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(4000) - 2000;
      default: return $urandom_range(400) - 200;
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    case (idx)
      REG_HIDDEN_MULT:  h_mult = v;
      REG_HIDDEN_SHIFT: h_shift = v[5:0];
      REG_HIDDEN_ZP:    h_zp = v[7:0];
      REG_SCORE_MULT:   s_mult = v;
      REG_SCORE_SHIFT:  s_shift = v[5:0];
      REG_SCORE_ZP:     s_zp = v[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid_i && scores_q.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic set_scales(logic [30:0] hm, logic [5:0] hs, logic [7:0] hz,
                            logic [30:0] sm, logic [5:0] ss, logic [7:0] sz);
    drain();
    write_reg(REG_HIDDEN_MULT, hm);            write_reg(REG_HIDDEN_SHIFT, CFG_W'(hs));
    write_reg(REG_HIDDEN_ZP, CFG_W'(hz));      write_reg(REG_SCORE_MULT, sm);
    write_reg(REG_SCORE_SHIFT, CFG_W'(ss));    write_reg(REG_SCORE_ZP, CFG_W'(sz));
  endtask

  task automatic load_all();
    for (int a = 0; a < 292; a++)
      pending_q.push_back(load_word(a, (a >= 128 && a < 160) || a >= 288 ?
                                         rnd_bias() : $urandom()));
  endtask

  initial begin
    h_mult = 31'd1073741824; h_shift = 6'd31; h_zp = '0;
    s_mult = 31'd1073741824; s_shift = 6'd31; s_zp = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: fill the store, then extremes at reset scales
    load_all();
    pending_q.push_back(load_word(300, 32'h7fffffff));   // beyond the store, ignored
    pending_q.push_back(load_word(511, 32'h80000000));
    pending_q.push_back(feat_word(8'h7f, 8'h7f, 8'h7f, 8'h7f));
    pending_q.push_back(feat_word(8'h80, 8'h80, 8'h80, 8'h80));
    pending_q.push_back(feat_word(8'd0, 8'd0, 8'd0, 8'd0));
    pending_q.push_back(feat_word(8'h7f, 8'h80, 8'h7f, 8'h80));
    // all-equal scores: zero weights in layer two, equal biases
    for (int a = 160; a < 288; a++) pending_q.push_back(load_word(a, 32'h00000100));
    for (int a = 288; a < 292; a++) pending_q.push_back(load_word(a, 32'd5));
    pending_q.push_back(feat_word(8'd1, 8'd2, 8'd3, 8'd4));
    pending_q.push_back(feat_word(8'h80, 8'h7f, 8'h80, 8'h7f));
    // saturation: huge biases, gain above one
    set_scales(31'h7fffffff, 6'd0, 8'h80, 31'h7fffffff, 6'd0, 8'h7f);
    pending_q.push_back(load_word(288, 32'h7fffffff));
    pending_q.push_back(load_word(289, 32'h80000000));
    pending_q.push_back(feat_word(8'h7f, 8'd3, 8'h80, 8'd9));
    pending_q.push_back(feat_word(8'h80, 8'h80, 8'h7f, 8'h7f));
    set_scales(31'd0, 6'd62, 8'h7f, 31'd0, 6'd62, 8'h80);
    pending_q.push_back(feat_word(8'd5, 8'd6, 8'd7, 8'd8));
    set_scales(31'd1073741824, 6'd31, 8'd0, 31'd1073741824, 6'd31, 8'd0);
    load_all();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 60) begin
        // receiver stalls while words keep coming
        fork
          begin
            hold_rx = 1'b1;
            repeat (3000) @(posedge clk_i);
            hold_rx = 1'b0;
          end
        join_none
      end
      if (n == 200) begin quiet_tx = 1'b1; quiet_rx = 1'b1; end
      if (n == 300) begin quiet_tx = 1'b0; quiet_rx = 1'b0; end
      if (n % 100 == 99)
        set_scales(31'($urandom()), 6'($urandom_range(20, 40)), 8'($urandom_range(255)),
                   31'($urandom()), 6'($urandom_range(20, 40)), 8'($urandom_range(255)));
      if ($urandom_range(99) < 75)
        pending_q.push_back(feat_word(8'($urandom()), 8'($urandom()),
                                      8'($urandom()), 8'($urandom())));
      else
        pending_q.push_back(load_word(int'($urandom_range(511)),
                                      $urandom_range(1) ? rnd_bias() : $urandom()));
      wait (pending_q.size() < 4);
    end

    drain();
    if (n_fail == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
